[rtl/flas_pkg.sv]
`timescale 1ns / 1ps

package flas_pkg;

  localparam int unsigned NumRegs   = 7;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned HeightW   = 16;
  localparam int unsigned LevelW    = 3;

  localparam logic [RegIdxW-1:0] RegLevel1On  = 3'd0;
  localparam logic [RegIdxW-1:0] RegLevel1Off = 3'd1;
  localparam logic [RegIdxW-1:0] RegLevel2On  = 3'd2;
  localparam logic [RegIdxW-1:0] RegLevel2Off = 3'd3;
  localparam logic [RegIdxW-1:0] RegLevel3On  = 3'd4;
  localparam logic [RegIdxW-1:0] RegLevel3Off = 3'd5;
  localparam logic [RegIdxW-1:0] RegReminder  = 3'd6;

  localparam logic [LevelW-1:0] LevelNormal = 3'd0;
  localparam logic [LevelW-1:0] LevelOne    = 3'd1;
  localparam logic [LevelW-1:0] LevelTwo    = 3'd2;
  localparam logic [LevelW-1:0] LevelThree  = 3'd3;
  localparam logic [LevelW-1:0] LevelFour   = 3'd4;

  // Thresholds in hundredths of a centimeter.
  localparam logic signed [HeightW-1:0] ThreshL1 = 16'sd1016;
  localparam logic signed [HeightW-1:0] ThreshL2 = 16'sd3048;
  localparam logic signed [HeightW-1:0] ThreshL3 = 16'sd7620;
  localparam logic signed [HeightW-1:0] ThreshL4 = 16'sd12192;

  typedef logic [NumRegs-1:0][TimeW-1:0] flas_regs_t;

  localparam flas_regs_t RegResetVals = {
    32'd60000, 32'd5000, 32'd30000, 32'd5000, 32'd20000, 32'd5000, 32'd10000
  };

  typedef struct packed {
    logic              siren_state;
    logic [TimeW-1:0]  siren_mark;
    logic [LevelW-1:0] last_alert_level;
    logic [TimeW-1:0]  alert_mark;
  } flas_state_t;

  typedef struct packed {
    logic [LevelW-1:0] flood_level;
    logic              siren_on;
    logic              alert_send;
    logic [LevelW-1:0] alert_level;
  } flas_result_t;

endpackage

[rtl/flas_in_if.sv]
`timescale 1ns / 1ps

interface flas_in_if;
  logic                                      valid;
  logic                                      ready;
  logic [flas_pkg::TimeW-1:0]                now_ms;
  logic signed [flas_pkg::HeightW-1:0]       water_height;

  modport source(output valid, output now_ms, output water_height, input ready);
  modport sink(input valid, input now_ms, input water_height, output ready);
endinterface

[rtl/flas_out_if.sv]
`timescale 1ns / 1ps

interface flas_out_if;
  logic                        valid;
  logic                        ready;
  logic [flas_pkg::LevelW-1:0] flood_level;
  logic                        siren_on;
  logic                        alert_send;
  logic [flas_pkg::LevelW-1:0] alert_level;

  modport source(output valid, output flood_level, output siren_on, output alert_send,
                 output alert_level, input ready);
  modport sink(input valid, input flood_level, input siren_on, input alert_send,
               input alert_level, output ready);
endinterface

[rtl/flas_cfg_if.sv]
`timescale 1ns / 1ps

interface flas_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [flas_pkg::RegIdxW-1:0] reg_index;
  logic [flas_pkg::TimeW-1:0]   wr_data;

  modport source(output valid, output reg_index, output wr_data, input ready);
  modport sink(input valid, input reg_index, input wr_data, output ready);
endinterface

[rtl/flood_level_alarm_sequencer.sv]
`timescale 1ns / 1ps
// Channel  Direction  Payload
// in_i     sink       now_ms (32), water_height (16, signed)
// out_o    source     flood_level (3), siren_on (1), alert_send (1), alert_level (3)
// cfg_i    sink       reg_index (3), wr_data (32); always ready
//
// Every input word produces one result word, valid on the output once the result register takes it:
// the word sits in the input register while the step logic feeds the result register.
// A new word is accepted every cycle while the result is not stalled; the limit is the state update loop.
// Reset loads the register defaults and clears the siren and alert state.
// A stalled result holds the input register, which still takes a word while it is empty.

module flood_level_alarm_sequencer (
  input logic          clk_i,
  input logic          rst_ni,
  flas_in_if.sink      in_i,
  flas_out_if.source   out_o,
  flas_cfg_if.sink     cfg_i
);
  import flas_pkg::*;

  logic                       s1_valid_q;
  logic [TimeW-1:0]           s1_now_q;
  logic signed [HeightW-1:0]  s1_height_q;
  logic                       out_valid_q;
  flas_result_t               out_res_q;
  flas_state_t                state_q;
  flas_state_t                state_d;
  flas_result_t               res_d;
  flas_regs_t                 regs_q;
  logic                       advance;
  logic                       in_take;

  assign advance     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || advance;
  assign in_take     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  flas_step u_step (
    .state_i        (state_q),
    .regs_i         (regs_q),
    .now_ms_i       (s1_now_q),
    .water_height_i (s1_height_q),
    .state_o        (state_d),
    .result_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= RegResetVals;
    end else if (cfg_i.valid && (cfg_i.reg_index < RegIdxW'(NumRegs))) begin
      regs_q[cfg_i.reg_index] <= cfg_i.wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_now_q    <= in_i.now_ms;
      s1_height_q <= in_i.water_height;
    end
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.flood_level = out_res_q.flood_level;
  assign out_o.siren_on    = out_res_q.siren_on;
  assign out_o.alert_send  = out_res_q.alert_send;
  assign out_o.alert_level = out_res_q.alert_level;

endmodule

[rtl/flas_step.sv]
`timescale 1ns / 1ps

module flas_step (
  input  flas_pkg::flas_state_t              state_i,
  input  flas_pkg::flas_regs_t               regs_i,
  input  logic [flas_pkg::TimeW-1:0]         now_ms_i,
  input  logic signed [flas_pkg::HeightW-1:0] water_height_i,
  output flas_pkg::flas_state_t              state_o,
  output flas_pkg::flas_result_t             result_o
);
  import flas_pkg::*;

  logic [LevelW-1:0] level;
  logic [TimeW-1:0]  siren_elapsed;
  logic [TimeW-1:0]  alert_elapsed;
  logic [TimeW-1:0]  on_time;
  logic [TimeW-1:0]  off_time;
  logic [TimeW-1:0]  span;

  always_comb begin
    if (water_height_i < ThreshL1) begin
      level = LevelNormal;
    end else if (water_height_i <= ThreshL2) begin
      level = LevelOne;
    end else if (water_height_i <= ThreshL3) begin
      level = LevelTwo;
    end else if (water_height_i <= ThreshL4) begin
      level = LevelThree;
    end else begin
      level = LevelFour;
    end
  end

  assign siren_elapsed = now_ms_i - state_i.siren_mark;
  assign alert_elapsed = now_ms_i - state_i.alert_mark;

  always_comb begin
    case (level)
      LevelTwo: begin
        on_time  = regs_i[RegLevel2On];
        off_time = regs_i[RegLevel2Off];
      end
      LevelThree: begin
        on_time  = regs_i[RegLevel3On];
        off_time = regs_i[RegLevel3Off];
      end
      default: begin
        on_time  = regs_i[RegLevel1On];
        off_time = regs_i[RegLevel1Off];
      end
    endcase
    span = state_i.siren_state ? on_time : off_time;
  end

  always_comb begin
    state_o              = state_i;
    result_o             = '0;
    result_o.flood_level = level;

    case (level)
      LevelNormal: state_o.siren_state = 1'b0;
      LevelOne, LevelTwo, LevelThree: begin
        if (siren_elapsed >= span) begin
          state_o.siren_mark  = now_ms_i;
          state_o.siren_state = ~state_i.siren_state;
        end
      end
      default: state_o.siren_state = 1'b1;
    endcase
    result_o.siren_on = state_o.siren_state;

    if (level == LevelNormal) begin
      if (state_i.last_alert_level != LevelNormal) begin
        result_o.alert_send      = 1'b1;
        state_o.last_alert_level = LevelNormal;
      end
    end else if (level != state_i.last_alert_level) begin
      result_o.alert_send      = 1'b1;
      result_o.alert_level     = level;
      state_o.last_alert_level = level;
      state_o.alert_mark       = now_ms_i;
    end else if (alert_elapsed >= regs_i[RegReminder]) begin
      result_o.alert_send  = 1'b1;
      result_o.alert_level = level;
      state_o.alert_mark   = now_ms_i;
    end
  end

endmodule

[rtl/flas_checker.sv]
`timescale 1ns / 1ps

module flas_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [flas_pkg::LevelW-1:0] flood_level_i,
  input logic                        siren_on_i,
  input logic                        alert_send_i,
  input logic [flas_pkg::LevelW-1:0] alert_level_i
);
  import flas_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(flood_level_i)
      && $stable(siren_on_i) && $stable(alert_send_i) && $stable(alert_level_i))
    else $error("result word changed while stalled");

  a_quiet_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !alert_send_i |-> alert_level_i == LevelNormal)
    else $error("alert level set without an alert");

  a_alert_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && alert_send_i |-> alert_level_i == flood_level_i)
    else $error("alert level differs from the classified level");

  a_siren_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && flood_level_i == LevelNormal |-> !siren_on_i)
    else $error("siren on at normal level");

  a_siren_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && flood_level_i == LevelFour |-> siren_on_i)
    else $error("siren off at level four");

endmodule

bind flood_level_alarm_sequencer flas_checker u_flas_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .flood_level_i (out_o.flood_level),
  .siren_on_i    (out_o.siren_on),
  .alert_send_i  (out_o.alert_send),
  .alert_level_i (out_o.alert_level)
);

[bench/tb_flood_level_alarm_sequencer.sv]
`timescale 1ns / 1ps

module tb_flood_level_alarm_sequencer;
  import flas_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 48;
  localparam logic [RegIdxW-1:0] RegUnused = 3'd7;

  typedef enum logic {RowWord, RowReg} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [TimeW-1:0]   val;
    int                 height;
    logic [RegIdxW-1:0] idx;
    bit                 typed;
    flas_result_t       want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  flas_in_if  in_if();
  flas_out_if out_if();
  flas_cfg_if cfg_if();

  flood_level_alarm_sequencer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #10 clk_i = ~clk_i;

  // Shadow of the block's registers and alarm state.
  logic [TimeW-1:0]  m_regs [NumRegs];
  logic              m_siren;
  logic [TimeW-1:0]  m_siren_mark;
  logic [LevelW-1:0] m_alert_lvl;
  logic [TimeW-1:0]  m_alert_mark;

  flas_result_t due_results[$];
  dir_row_t     dir_rows[$];

  int  errors = 0;
  int  cycle_count = 0;
  int  words_sent = 0;
  int  results_checked = 0;
  int  alerts_seen = 0;
  int  siren_seen = 0;
  int  in_stalls = 0;
  int  cur_level = 0;
  bit  idle_on = 1'b0;
  bit  hold_out = 1'b0;

  int lo_of [5] = '{-32768, 1016, 3049, 7621, 12193};
  int hi_of [5] = '{1015, 3048, 7620, 12192, 32767};

  function automatic logic [LevelW-1:0] level_of(logic signed [HeightW-1:0] h);
    if (h < ThreshL1) return LevelNormal;
    if (h <= ThreshL2) return LevelOne;
    if (h <= ThreshL3) return LevelTwo;
    if (h <= ThreshL4) return LevelThree;
    return LevelFour;
  endfunction

  function automatic flas_result_t step_alarm(logic [TimeW-1:0] now,
                                              logic signed [HeightW-1:0] h);
    flas_result_t     res;
    logic [TimeW-1:0] span;
    logic [TimeW-1:0] siren_gap;
    logic [TimeW-1:0] alert_gap;
    int               base;
    res = '0;
    res.flood_level = level_of(h);
    siren_gap = now - m_siren_mark;
    alert_gap = now - m_alert_mark;
    if (res.flood_level == LevelNormal) begin
      m_siren = 1'b0;
    end else if (res.flood_level == LevelFour) begin
      m_siren = 1'b1;
    end else begin
      base = (int'(res.flood_level) - 1) * 2;
      span = m_siren ? m_regs[base] : m_regs[base + 1];
      if (siren_gap >= span) begin
        m_siren_mark = now;
        m_siren = ~m_siren;
      end
    end
    res.siren_on = m_siren;
    if (res.flood_level == LevelNormal) begin
      if (m_alert_lvl != LevelNormal) begin
        res.alert_send = 1'b1;
        m_alert_lvl = LevelNormal;
      end
    end else if (res.flood_level != m_alert_lvl) begin
      res.alert_send = 1'b1;
      res.alert_level = res.flood_level;
      m_alert_lvl = res.flood_level;
      m_alert_mark = now;
    end else if (alert_gap >= m_regs[RegReminder]) begin
      res.alert_send = 1'b1;
      res.alert_level = res.flood_level;
      m_alert_mark = now;
    end
    return res;
  endfunction

  task automatic send_word(input logic [TimeW-1:0] now, input int h, input bit typed,
                           input flas_result_t want);
    flas_result_t res;
    in_if.valid <= 1'b1;
    in_if.now_ms <= now;
    in_if.water_height <= h[HeightW-1:0];
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    res = step_alarm(now, h[HeightW-1:0]);
    due_results.push_back(typed ? want : res);
    words_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [TimeW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wr_data <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (idx < NumRegs) m_regs[idx] = data;
  endtask

  task automatic program_regs(input flas_regs_t vals);
    drain();
    for (int i = 0; i < NumRegs; i++) write_reg(RegIdxW'(i), vals[i]);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(input int n_words, input int tick_max, input bit allow_idle,
                           input bit with_pressure);
    logic [TimeW-1:0] now;
    int               h;
    int               burst;
    burst = 0;
    now = $urandom();
    for (int k = 0; k < n_words; k++) begin
      if (k % 30 == 0) idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      if (with_pressure && k == 30) begin
        hold_out = 1'b1;
        burst = 14;
      end
      if (with_pressure && k == 60) drain();
      case ($urandom_range(0, 39))
        0: now = $urandom();
        1: now = m_siren_mark - 32'd1;
        2: now = m_alert_mark - 32'd1;
        default: now = now + $urandom_range(0, tick_max);
      endcase
      if ($urandom_range(0, 3) == 0) cur_level = $urandom_range(0, 4);
      case ($urandom_range(0, 19))
        0: h = $signed(16'($urandom()));
        1, 2: h = lo_of[cur_level];
        3, 4: h = hi_of[cur_level];
        default: h = lo_of[cur_level] + $urandom_range(0, hi_of[cur_level] - lo_of[cur_level]);
      endcase
      send_word(now, h, 1'b0, '0);
      if (burst > 0) begin
        burst--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
    end
  endtask

  // Result side: random backpressure, plus one long hold on request.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_out = 1'b0;
        out_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    flas_result_t want;
    if (rst_ni && in_if.valid && !in_if.ready) in_stalls++;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result word: level %0d", out_if.flood_level);
        errors++;
      end else begin
        want = due_results.pop_front();
        results_checked++;
        if (out_if.alert_send) alerts_seen++;
        if (out_if.siren_on) siren_seen++;
        if (out_if.flood_level !== want.flood_level) begin
          $error("flood_level: expected %0d, got %0d", want.flood_level, out_if.flood_level);
          errors++;
        end
        if (out_if.siren_on !== want.siren_on) begin
          $error("siren_on: expected %0d, got %0d", want.siren_on, out_if.siren_on);
          errors++;
        end
        if (out_if.alert_send !== want.alert_send) begin
          $error("alert_send: expected %0d, got %0d", want.alert_send, out_if.alert_send);
          errors++;
        end
        if (out_if.alert_level !== want.alert_level) begin
          $error("alert_level: expected %0d, got %0d", want.alert_level, out_if.alert_level);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, due_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    flas_regs_t cfg_set;
    bit         cfg_open;
    int         n_directed;
    in_if.valid <= 1'b0;
    in_if.now_ms <= '0;
    in_if.water_height <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.reg_index <= '0;
    cfg_if.wr_data <= '0;
    for (int i = 0; i < NumRegs; i++) m_regs[i] = RegResetVals[i];
    m_siren = 1'b0;
    m_siren_mark = '0;
    m_alert_lvl = LevelNormal;
    m_alert_mark = '0;
    cfg_open = 1'b0;

    // Typed rows follow from the reset defaults; the rest use the shadow state.
    dir_rows = '{
      '{RowWord, 32'd0, -32768, RegLevel1On, 1'b1, '{LevelNormal, 1'b0, 1'b0, LevelNormal}},
      '{RowWord, 32'd1, 1015, RegLevel1On, 1'b1, '{LevelNormal, 1'b0, 1'b0, LevelNormal}},
      '{RowWord, 32'd2, 1016, RegLevel1On, 1'b1, '{LevelOne, 1'b0, 1'b1, LevelOne}},
      '{RowWord, 32'd5000, 3048, RegLevel1On, 1'b1, '{LevelOne, 1'b1, 1'b0, LevelNormal}},
      '{RowWord, 32'd5001, 3049, RegLevel1On, 1'b0, '0},
      '{RowWord, 32'd5002, 7620, RegLevel1On, 1'b0, '0},
      '{RowWord, 32'd5003, 7621, RegLevel1On, 1'b0, '0},
      '{RowWord, 32'd5004, 12192, RegLevel1On, 1'b0, '0},
      '{RowWord, 32'd5005, 12193, RegLevel1On, 1'b1, '{LevelFour, 1'b1, 1'b1, LevelFour}},
      '{RowWord, 32'd65005, 32767, RegLevel1On, 1'b1, '{LevelFour, 1'b1, 1'b1, LevelFour}},
      '{RowWord, 32'd65006, 20000, RegLevel1On, 1'b1, '{LevelFour, 1'b1, 1'b0, LevelNormal}},
      '{RowWord, 32'hFFFF_FFF0, 12193, RegLevel1On, 1'b0, '0},
      '{RowWord, 32'h0000_0010, 500, RegLevel1On, 1'b1, '{LevelNormal, 1'b0, 1'b1, LevelNormal}},
      '{RowWord, 32'h0000_0020, 0, RegLevel1On, 1'b1, '{LevelNormal, 1'b0, 1'b0, LevelNormal}},
      '{RowWord, 32'h8000_0000, 2000, RegLevel1On, 1'b0, '0},
      '{RowReg, 32'd0, 0, RegLevel1On, 1'b0, '0},
      '{RowReg, 32'd0, 0, RegLevel1Off, 1'b0, '0},
      '{RowReg, 32'd0, 0, RegReminder, 1'b0, '0},
      '{RowReg, 32'hDEAD_BEEF, 0, RegUnused, 1'b0, '0},
      '{RowWord, 32'h8000_0001, 1500, RegLevel1On, 1'b0, '0},
      '{RowWord, 32'h8000_0001, 1500, RegLevel1On, 1'b0, '0},
      '{RowWord, 32'h8000_0001, 1500, RegLevel1On, 1'b0, '0},
      '{RowWord, 32'h8000_0002, 5000, RegLevel1On, 1'b0, '0},
      '{RowWord, 32'h8000_0003, -1, RegLevel1On, 1'b1, '{LevelNormal, 1'b0, 1'b1, LevelNormal}}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowReg) begin
        if (!cfg_open) begin
          drain();
          cfg_open = 1'b1;
        end
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        if (cfg_open) begin
          cfg_if.valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_word(dir_rows[i].val, dir_rows[i].height, dir_rows[i].typed, dir_rows[i].want);
      end
    end
    n_directed = words_sent;

    program_regs(RegResetVals);
    run_phase(90, 8000, 1'b1, 1'b0);

    for (int i = 0; i < NumRegs; i++) cfg_set[i] = $urandom_range(1, 20);
    cfg_set[RegReminder] = $urandom_range(1, 40);
    program_regs(cfg_set);
    run_phase(90, 12, 1'b1, 1'b1);

    for (int i = 0; i < NumRegs; i++) cfg_set[i] = 32'd1;
    program_regs(cfg_set);
    run_phase(90, 3, 1'b1, 1'b0);

    for (int i = 0; i < NumRegs; i++) cfg_set[i] = 32'hFFFF_FFFF;
    program_regs(cfg_set);
    run_phase(90, 5000, 1'b1, 1'b0);

    for (int i = 0; i < NumRegs; i++) begin
      cfg_set[i] = ($urandom_range(0, 1) != 0) ? 32'($urandom_range(1, 60)) : 32'($urandom());
    end
    program_regs(cfg_set);
    run_phase(90, 50, 1'b0, 1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d words (%0d directed) over five register settings, checked %0d results.",
             words_sent, n_directed, results_checked);
    $display("Saw %0d alerts and %0d siren-on results; input stalled %0d cycles.",
             alerts_seen, siren_seen, in_stalls);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
